FILE: sv/kesd_pkg.sv
// ----------------------------------------------------------------------------
// kesd_pkg: shared types and constants of the key escape sequence decoder
// Field widths, request codes and the structs that pass between the
// controller and the row of table cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kesd_pkg;

    localparam int BYTE_W        = 8;
    localparam int ENTRY_IDX_W   = 5;
    localparam int ENTRY_BYTES_W = 64;
    localparam int ENTRY_LEN_W   = 4;
    localparam int KEY_CODE_W    = 16;
    localparam int OUT_VALUE_W   = 16;
    // Number of sequence bytes that one entry_bytes word can carry.
    localparam int BYTE_SLOTS    = ENTRY_BYTES_W / BYTE_W;

    // Request kinds.
    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Table write broadcast to every cell.
    typedef struct packed {
        logic                     valid;
        logic [ENTRY_IDX_W-1:0]   index;
        logic [ENTRY_BYTES_W-1:0] bytes;
        logic [ENTRY_LEN_W-1:0]   len;
        logic [KEY_CODE_W-1:0]    code;
    } t_load;

    // Search token that travels down the row of cells.
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic                  partial;
        logic [KEY_CODE_W-1:0] code;
    } t_scan;

endpackage

`default_nettype wire

FILE: sv/kesd_if.sv
// ----------------------------------------------------------------------------
// kesd_if: request and result channels of the key escape sequence decoder
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kesd_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [kesd_pkg::BYTE_W-1:0]        rx_byte;
    logic [kesd_pkg::ENTRY_IDX_W-1:0]   entry_index;
    logic [kesd_pkg::ENTRY_BYTES_W-1:0] entry_bytes;
    logic [kesd_pkg::ENTRY_LEN_W-1:0]   entry_length;
    logic [kesd_pkg::KEY_CODE_W-1:0]    entry_key_code;

    modport source (
        output valid, req_type, rx_byte, entry_index, entry_bytes, entry_length,
               entry_key_code,
        input  ready
    );
    modport sink (
        input  valid, req_type, rx_byte, entry_index, entry_bytes, entry_length,
               entry_key_code,
        output ready
    );
endinterface

interface kesd_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [kesd_pkg::OUT_VALUE_W-1:0] out_value;
    logic                             is_key_code;
    logic                             last;

    modport source (
        output valid, out_value, is_key_code, last,
        input  ready
    );
    modport sink (
        input  valid, out_value, is_key_code, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/kesd_cell.sv
// ----------------------------------------------------------------------------
// kesd_cell: one key table entry with its slice of the search chain
// Holds one sequence, compares it with the pending bytes when the search
// token passes, and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kesd_cell #(
    parameter int CELL_ID = 0,
    parameter int SEQ_CAP = 8
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire kesd_pkg::t_load                         i_load,
    input  wire [SEQ_CAP-1:0][kesd_pkg::BYTE_W-1:0]      i_pend,
    input  wire [$clog2(SEQ_CAP+1)-1:0]                  i_count,
    input  wire kesd_pkg::t_scan                         i_tok,
    output kesd_pkg::t_scan                              o_tok
);

    localparam int CNT_W = $clog2(SEQ_CAP + 1);
    localparam logic [31:0] ID = 32'(CELL_ID);

    logic [kesd_pkg::ENTRY_BYTES_W-1:0] r_bytes;
    logic [kesd_pkg::ENTRY_LEN_W-1:0]   r_len;
    logic [kesd_pkg::KEY_CODE_W-1:0]    r_code;
    kesd_pkg::t_scan                    r_tok;
    kesd_pkg::t_scan                    n_tok;

    logic                               w_wr;
    logic                               w_mismatch;
    logic                               w_hit;
    logic [kesd_pkg::ENTRY_LEN_W-1:0]   w_n;

    assign w_wr = i_load.valid && (32'(i_load.index) == ID);
    assign w_n  = kesd_pkg::ENTRY_LEN_W'(i_count);

    // Only the first i_count bytes take part in the compare.
    always_comb begin
        w_mismatch = 1'b0;
        for (int k = 0; k < SEQ_CAP; k++) begin
            if ((CNT_W'(k) < i_count) &&
                (r_bytes[kesd_pkg::BYTE_W*k +: kesd_pkg::BYTE_W] != i_pend[k])) begin
                w_mismatch = 1'b1;
            end
        end
    end

    assign w_hit = (r_len != '0) && (r_len >= w_n) && !w_mismatch;

    // The earliest full match in the row keeps its code.
    always_comb begin
        n_tok         = i_tok;
        n_tok.found   = i_tok.found || (w_hit && (r_len == w_n));
        n_tok.partial = i_tok.partial || (w_hit && (r_len > w_n));
        n_tok.code    = i_tok.found ? i_tok.code : r_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            if (w_wr) begin
                r_len <= i_load.len;
            end
            r_tok.valid <= n_tok.valid;
        end
        if (w_wr) begin
            r_bytes <= i_load.bytes;
            r_code  <= i_load.code;
        end
        r_tok.found   <= n_tok.found;
        r_tok.partial <= n_tok.partial;
        r_tok.code    <= n_tok.code;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: sv/key_escape_sequence_decoder_unit.sv
// ----------------------------------------------------------------------------
// key_escape_sequence_decoder_unit: terminal key escape sequence decoder
// Turns received terminal bytes into extended key codes with a loadable
// table of byte sequences held in a row of compare cells.
// ----------------------------------------------------------------------------
// A load request writes one table slot and gives no result; a slot index at
// or above NUM_KEYS is ignored and a length above the usable maximum (the
// smaller of MAX_SEQ_LEN and 8) is saturated. A received byte is appended
// to the pending buffer and a search token is then sent down the row of
// NUM_KEYS cells, one cell per cycle, so the time to resolve a byte grows
// with the length of that cell row. Results then leave at one per cycle while
// the sink is ready: a single key code on a full match, every pending byte on
// a miss, or nothing while the buffer is still a prefix of some entry. New
// requests are taken only once the previous one is fully resolved, but the
// last result of a request may still wait in the output register while the
// next request is accepted. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_escape_sequence_decoder_unit #(
    parameter int NUM_KEYS    = 32,
    parameter int MAX_SEQ_LEN = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    kesd_req_if.sink    i_req,
    kesd_rsp_if.source  o_rsp
);

    // Longest sequence that an entry can hold, and so the pending buffer depth.
    localparam int SEQ_CAP = (MAX_SEQ_LEN < kesd_pkg::BYTE_SLOTS) ?
                             MAX_SEQ_LEN : kesd_pkg::BYTE_SLOTS;
    localparam int CNT_W   = $clog2(SEQ_CAP + 1);
    localparam int PIDX_W  = $clog2(SEQ_CAP);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                                  r_state, n_state;
    logic [SEQ_CAP-1:0][kesd_pkg::BYTE_W-1:0] r_pend;
    logic [CNT_W-1:0]                        r_count, n_count;
    logic                                    r_launch, n_launch;
    logic                                    r_key, n_key;
    logic [kesd_pkg::KEY_CODE_W-1:0]         r_code, n_code;
    logic [PIDX_W-1:0]                       r_idx, n_idx;
    logic                                    r_ovalid, n_ovalid;
    logic [kesd_pkg::OUT_VALUE_W-1:0]        r_oval, n_oval;
    logic                                    r_okey, n_okey;
    logic                                    r_olast, n_olast;

    logic                                    w_acc;
    logic                                    w_rx_acc;
    logic                                    w_emit_last;
    kesd_pkg::t_load                         w_load;
    kesd_pkg::t_scan                         w_tok [NUM_KEYS+1];

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_rx_acc    = w_acc && (i_req.req_type == kesd_pkg::REQ_RX);

    // Table write, with the length held to what an entry can carry.
    always_comb begin
        w_load.valid = w_acc && (i_req.req_type == kesd_pkg::REQ_LOAD);
        w_load.index = i_req.entry_index;
        w_load.bytes = i_req.entry_bytes;
        w_load.len   = (i_req.entry_length > kesd_pkg::ENTRY_LEN_W'(SEQ_CAP)) ?
                       kesd_pkg::ENTRY_LEN_W'(SEQ_CAP) : i_req.entry_length;
        w_load.code  = i_req.entry_key_code;
    end

    // The token enters the row in the same cycle as the byte lands in the buffer.
    always_comb begin
        w_tok[0].valid   = r_launch;
        w_tok[0].found   = 1'b0;
        w_tok[0].partial = 1'b0;
        w_tok[0].code    = '0;
    end

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
        kesd_cell #(
            .CELL_ID (g),
            .SEQ_CAP (SEQ_CAP)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_pend  (r_pend),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // A key code is always a single result; raw bytes end at the newest one.
    assign w_emit_last = r_key || ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_launch = 1'b0;
        n_key    = r_key;
        n_code   = r_code;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_okey   = r_okey;
        n_olast  = r_olast;
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_rx_acc) begin
                    n_count  = r_count + CNT_W'(1);
                    n_launch = 1'b1;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tok[NUM_KEYS].valid) begin
                    n_idx  = '0;
                    n_key  = w_tok[NUM_KEYS].found;
                    n_code = w_tok[NUM_KEYS].code;
                    if (!w_tok[NUM_KEYS].found && w_tok[NUM_KEYS].partial) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_key ? r_code :
                               kesd_pkg::OUT_VALUE_W'(r_pend[r_idx]);
                    n_okey   = r_key;
                    n_olast  = w_emit_last;
                    if (w_emit_last) begin
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + PIDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_launch <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_launch <= n_launch;
            r_ovalid <= n_ovalid;
        end
        r_key   <= n_key;
        r_code  <= n_code;
        r_idx   <= n_idx;
        r_oval  <= n_oval;
        r_okey  <= n_okey;
        r_olast <= n_olast;
    end

    // Pending buffer: only the first r_count entries are ever read.
    always_ff @(posedge i_clk) begin
        if (w_rx_acc) begin
            r_pend[r_count[PIDX_W-1:0]] <= i_req.rx_byte;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.out_value   = r_oval;
    assign o_rsp.is_key_code = r_okey;
    assign o_rsp.last        = r_olast;

    // The search token leaves the row only while the controller waits for it.
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[NUM_KEYS].valid |-> (r_state == ST_SCAN))
        else $error("search token left the cell row outside of a scan");

    // The buffer never grows beyond the longest sequence an entry can hold.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) <= SEQ_CAP))
        else $error("pending byte count exceeds the sequence capacity");

    // An accepted byte always starts a search on the next cycle.
    a_rx_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rx_acc |=> (r_launch && (r_state == ST_SCAN)))
        else $error("received byte did not start a search");

    // A full match always leads to a key code result.
    a_match_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok[NUM_KEYS].valid && w_tok[NUM_KEYS].found) |=>
        ((r_state == ST_EMIT) && r_key))
        else $error("full match did not select a key code result");

    // A key code result is always the only result of its request.
    a_key_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_okey) |-> r_olast)
        else $error("key code result not marked as last");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for key_escape_sequence_decoder_unit
// Loads key tables and streams terminal bytes into the decoder. An
// independent decoder in the bench predicts every key code and raw byte, and
// each returned result is checked in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_KEYS    = 32;
    localparam int MAX_SEQ_LEN = 8;
    // Longest sequence an entry can really hold: bounded by the parameter and
    // by the eight bytes that one entry word carries.
    localparam int SEQ_CAP     = (MAX_SEQ_LEN < kesd_pkg::BYTE_SLOTS) ?
                                 MAX_SEQ_LEN : kesd_pkg::BYTE_SLOTS;
    localparam int ITEM_TARGET = 380;
    // The long receiver hold-off starts once this many requests have gone in.
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 400;

    // One request as the sender offers it.
    typedef struct packed {
        logic                               kind;
        logic [kesd_pkg::BYTE_W-1:0]        rx_byte;
        logic [kesd_pkg::ENTRY_IDX_W-1:0]   idx;
        logic [kesd_pkg::ENTRY_BYTES_W-1:0] seq;
        logic [kesd_pkg::ENTRY_LEN_W-1:0]   len;
        logic [kesd_pkg::KEY_CODE_W-1:0]    code;
    } t_req;

    // One decoded result: a key code or a single raw byte.
    typedef struct packed {
        logic [kesd_pkg::OUT_VALUE_W-1:0] value;
        logic                             is_key;
        logic                             last;
    } t_rsp;

    logic clk;
    logic rst_n = 1'b0;

    kesd_req_if req_bus ();
    kesd_rsp_if rsp_bus ();

    key_escape_sequence_decoder_unit #(
        .NUM_KEYS    (NUM_KEYS),
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // Requests waiting to be offered, and results the bench decoder has
    // produced that the block has not yet returned.
    t_req stim_q [$];
    t_rsp decoded_q [$];

    // The bench decoder's own key table and pending byte buffer.
    logic [kesd_pkg::ENTRY_BYTES_W-1:0] key_seq  [NUM_KEYS];
    int unsigned                        key_len  [NUM_KEYS];
    logic [kesd_pkg::KEY_CODE_W-1:0]    key_code [NUM_KEYS];
    logic [kesd_pkg::BYTE_W-1:0]        held     [kesd_pkg::BYTE_SLOTS];
    int unsigned                        held_cnt = 0;

    // Shadow of the table as the stimulus builder loads it, so that random
    // byte streams can follow real entries.
    logic [kesd_pkg::ENTRY_BYTES_W-1:0] gen_seq [NUM_KEYS];
    int                                 gen_len [NUM_KEYS];

    int errors      = 0;
    int req_count   = 0;
    int load_count  = 0;
    int keys_seen   = 0;
    int raw_seen    = 0;
    int longest_run = 0;
    int total_items = 0;

    logic req_moved = 1'b0;
    t_req drv_item;
    t_req taken;
    t_rsp seen;
    t_rsp want;
    int   gap_left   = 0;
    int   burst_left = 0;
    int   rx_cycle   = 0;
    int   rx_mode    = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    bit   hold_done  = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bench decoder
    // ------------------------------------------------------------------------

    // Applies one accepted request: a load rewrites a slot, a byte is added
    // to the buffer and the buffer is resolved against the table. A full
    // match anywhere in the table beats a partial one, and among full
    // matches the lowest slot wins. With neither, the whole buffer comes
    // back as raw bytes, oldest first.
    task automatic decode_request(input t_req r);
        int  hit;
        bit  partial;
        bit  same;
        t_rsp res;
        if (r.kind == kesd_pkg::REQ_LOAD) begin
            load_count++;
            if (r.idx < NUM_KEYS) begin
                key_seq[r.idx]  = r.seq;
                key_len[r.idx]  = (32'(r.len) > SEQ_CAP) ? SEQ_CAP : 32'(r.len);
                key_code[r.idx] = r.code;
            end
        end else begin
            held[held_cnt] = r.rx_byte;
            held_cnt++;
            hit     = -1;
            partial = 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (hit < 0 && key_len[i] != 0 && key_len[i] >= held_cnt) begin
                    same = 1'b1;
                    for (int k = 0; k < held_cnt; k++)
                        if (key_seq[i][8*k +: 8] != held[k])
                            same = 1'b0;
                    if (same && key_len[i] == held_cnt)
                        hit = i;
                    else if (same)
                        partial = 1'b1;
                end
            end
            if (hit >= 0) begin
                res.value  = key_code[hit];
                res.is_key = 1'b1;
                res.last   = 1'b1;
                decoded_q.push_back(res);
                held_cnt = 0;
            end else if (!partial) begin
                for (int k = 0; k < held_cnt; k++) begin
                    res.value  = {8'h00, held[k]};
                    res.is_key = 1'b0;
                    res.last   = (k == held_cnt - 1);
                    decoded_q.push_back(res);
                end
                if (held_cnt > longest_run)
                    longest_run = held_cnt;
                held_cnt = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    task automatic push_load(input int idx,
                             input logic [kesd_pkg::ENTRY_BYTES_W-1:0] seq,
                             input int len,
                             input logic [kesd_pkg::KEY_CODE_W-1:0] code);
        t_req r;
        r.kind    = kesd_pkg::REQ_LOAD;
        r.rx_byte = kesd_pkg::BYTE_W'($urandom_range(0, 255));
        r.idx     = kesd_pkg::ENTRY_IDX_W'(idx);
        r.seq     = seq;
        r.len     = kesd_pkg::ENTRY_LEN_W'(len);
        r.code    = code;
        stim_q.push_back(r);
        gen_seq[idx] = seq;
        gen_len[idx] = (len > SEQ_CAP) ? SEQ_CAP : len;
    endtask

    // A received byte; the load fields are don't-care and get noise.
    task automatic push_byte(input logic [kesd_pkg::BYTE_W-1:0] b);
        t_req r;
        r.kind    = kesd_pkg::REQ_RX;
        r.rx_byte = b;
        r.idx     = kesd_pkg::ENTRY_IDX_W'($urandom_range(0, 31));
        r.seq     = {$urandom, $urandom};
        r.len     = kesd_pkg::ENTRY_LEN_W'($urandom_range(0, 15));
        r.code    = kesd_pkg::KEY_CODE_W'($urandom_range(0, 65535));
        stim_q.push_back(r);
    endtask

    // Bytes typical of terminal escape sequences, so entries share prefixes.
    function automatic logic [kesd_pkg::BYTE_W-1:0] pool_byte();
        case ($urandom_range(0, 8))
            0:       return 8'h5B;
            1:       return 8'h4F;
            2:       return 8'h41;
            3:       return 8'h42;
            4:       return 8'h31;
            5:       return 8'h7E;
            6:       return 8'h00;
            7:       return 8'h1B;
            default: return kesd_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Loads a random slot. Most entries start with escape, and up to a quarter
    // are a copy of another entry of two or more bytes with the final byte
    // redrawn, which gives near-collisions and duplicate prefixes.
    task automatic random_entry();
        logic [kesd_pkg::ENTRY_BYTES_W-1:0] seq;
        int len;
        int src;
        seq = {$urandom, $urandom};
        for (int k = 0; k < kesd_pkg::BYTE_SLOTS; k++)
            if ($urandom_range(0, 9) < 7)
                seq[8*k +: 8] = pool_byte();
        if ($urandom_range(0, 9) < 8)
            seq[7:0] = 8'h1B;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(9, 15);
            default: len = $urandom_range(1, 8);
        endcase
        src = $urandom_range(0, NUM_KEYS - 1);
        if ($urandom_range(0, 3) == 0 && gen_len[src] > 1) begin
            seq = gen_seq[src];
            len = gen_len[src];
            seq[8*(len-1) +: 8] = pool_byte();
        end
        push_load($urandom_range(0, NUM_KEYS - 1), seq, len,
                  kesd_pkg::KEY_CODE_W'($urandom_range(0, 65535)));
    endtask

    // ------------------------------------------------------------------------
    // Sender: holds each request until it is taken, and works in bursts of
    // random length separated by random gaps.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && (!req_bus.valid || req_moved)) begin
            if (gap_left > 0) begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end else if (stim_q.size() != 0) begin
                drv_item = stim_q.pop_front();
                req_bus.valid          <= 1'b1;
                req_bus.req_type       <= drv_item.kind;
                req_bus.rx_byte        <= drv_item.rx_byte;
                req_bus.entry_index    <= drv_item.idx;
                req_bus.entry_bytes    <= drv_item.seq;
                req_bus.entry_length   <= drv_item.len;
                req_bus.entry_key_code <= drv_item.code;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(1, 3);
                        2:       gap_left = $urandom_range(4, 12);
                        default: gap_left = $urandom_range(13, 40);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its stall pattern periodically draws a new mode from never
    // stalling, light stalls and heavy stalls. Once, after HOLD_AT requests, it
    // holds ready low through one long hold-off while the sender keeps
    // offering, so results back up and the block has to refuse requests.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        rx_cycle++;
        if (rx_cycle % 128 == 0)
            rx_mode = $urandom_range(0, 2);
        if (!hold_done && hold_left == 0 && req_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 8);
                default: stall_left = 0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: results are checked before the request taken at the same edge
    // is decoded, since such a result always belongs to an earlier request.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.out_value, rsp_bus.is_key_code, rsp_bus.last};
            if (seen.is_key)
                keys_seen++;
            else
                raw_seen++;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: result value %h key %b last %b with none outstanding",
                         $time, seen.value, seen.is_key, seen.last);
            end else begin
                want = decoded_q.pop_front();
                if (seen.value !== want.value) begin
                    errors++;
                    $display("%0t: out_value expected %h, got %h",
                             $time, want.value, seen.value);
                end
                if (seen.is_key !== want.is_key) begin
                    errors++;
                    $display("%0t: is_key_code expected %b, got %b",
                             $time, want.is_key, seen.is_key);
                end
                if (seen.last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b, got %b",
                             $time, want.last, seen.last);
                end
            end
        end
        if (rst_n && req_bus.valid && req_bus.ready) begin
            taken = {req_bus.req_type, req_bus.rx_byte, req_bus.entry_index,
                     req_bus.entry_bytes, req_bus.entry_length, req_bus.entry_key_code};
            decode_request(taken);
            req_count++;
        end
        req_moved <= rst_n && req_bus.valid && req_bus.ready;
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the whole stimulus, reset, then drain.
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        int slot;
        int s;
        int n;
        int cut;

        req_bus.valid          = 1'b0;
        req_bus.req_type       = kesd_pkg::REQ_RX;
        req_bus.rx_byte        = '0;
        req_bus.entry_index    = '0;
        req_bus.entry_bytes    = '0;
        req_bus.entry_length   = '0;
        req_bus.entry_key_code = '0;
        rsp_bus.ready          = 1'b0;

        // Directed part. A zero byte and an all-ones byte against an empty
        // table come straight back as raw bytes.
        push_byte(8'h00);
        push_byte(8'hFF);
        // Cursor-up style entry with junk above its length that must never be
        // compared, and an eight-byte entry with an oversize length that
        // saturates. The long one carries a zero byte as its second byte.
        push_load(0, {40'hA5A5A5A5A5, 24'h415B1B}, 3, 16'h0101);
        push_load(31, 64'h665544332211001B, 15, 16'hFFFF);
        // Slot marked absent by length zero: its byte must not match.
        push_load(5, 64'h000000000000007E, 0, 16'h1234);
        // Duplicate of slot 0 with another code; the lower slot must win.
        push_load(1, {40'h5A5A5A5A5A, 24'h415B1B}, 3, 16'h0202);
        // Single-byte key whose code is zero.
        push_load(2, 64'hFFFFFFFFFFFFFF7F, 1, 16'h0000);
        // Escape, bracket, then a load in the middle of the sequence: the
        // pending bytes must survive it.
        push_byte(8'h1B);
        push_byte(8'h5B);
        push_load(3, 64'h0000000000004F1B, 2, 16'h8000);
        push_byte(8'h41);
        push_byte(8'h7F);
        push_byte(8'h7E);
        push_byte(8'h1B);
        push_byte(8'h4F);
        // Seven bytes of the long entry and then a wrong one: the buffer is
        // full and the whole of it comes back, eight raw bytes in one run.
        for (int k = 0; k < 7; k++)
            push_byte(gen_seq[31][8*k +: 8]);
        push_byte(8'h99);

        // Random part: load ten random entries first, then mostly well-formed
        // sequences from it, some broken ones, noise bytes and reloads.
        repeat (10) random_entry();
        while (stim_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            slot = -1;
            repeat (8) begin
                s = $urandom_range(0, NUM_KEYS - 1);
                if (gen_len[s] != 0)
                    slot = s;
            end
            if (pick < 8) begin
                random_entry();
            end else if (pick < 88 && slot >= 0) begin
                n   = gen_len[slot];
                cut = (pick < 70) ? n : ((n > 1) ? $urandom_range(1, n - 1) : 0);
                for (int k = 0; k < cut; k++)
                    push_byte(gen_seq[slot][8*k +: 8]);
                if (pick >= 70)
                    push_byte(($urandom_range(0, 1) == 0) ? pool_byte() :
                              kesd_pkg::BYTE_W'($urandom_range(0, 255)));
            end else begin
                push_byte(kesd_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end
        total_items = stim_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_count < total_items)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        // The block walks every slot per byte; give it that long and more to
        // show any result that should not exist.
        repeat (2 * NUM_KEYS + 16) @(posedge clk);

        $display("Sent %0d requests (%0d table loads); got %0d key codes and %0d raw bytes.",
                 req_count, load_count, keys_seen, raw_seen);
        $display("Longest raw byte run %0d; output held off once for %0d cycles.",
                 longest_run, HOLD_CYCLES);
        if (errors == 0)
            $display("key_escape_sequence_decoder_unit: match");
        else
            $display("key_escape_sequence_decoder_unit: mismatch");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #1000000;
        $display("key_escape_sequence_decoder_unit: mismatch");
        $finish;
    end

endmodule

FILE: key_escape_sequence_decoder_unit.f
sv/kesd_pkg.sv
sv/kesd_if.sv
sv/kesd_cell.sv
sv/key_escape_sequence_decoder_unit.sv
tb/tb_top.sv
